FILE: design/cav_pkg.sv
// Shared widths, types, codes and multiply helpers for the conic arc validator.
package cav_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int WORD_BITS      = 32;
    localparam int TOL_BITS       = 31;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 32;
    localparam int FORM_BITS      = 2;
    localparam int KIND_BITS      = 2;
    localparam int POINTS         = 2;
    localparam int SUM_BITS       = 3 * WORD_BITS + 4;

    typedef logic signed [WORD_BITS-1:0]   word_t;
    typedef logic signed [2*WORD_BITS-1:0] dword_t;
    typedef logic signed [2*WORD_BITS:0]   part_t;
    typedef logic signed [SUM_BITS-1:0]    acc_t;
    typedef logic [SUM_BITS-1:0]           mag_t;
    typedef logic [TOL_BITS-1:0]           tol_t;
    typedef logic [KIND_BITS-1:0]          kind_t;
    typedef logic [FORM_BITS-1:0]          form_t;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ZERO_TOL = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_GEOM_TOL = CFG_INDEX_BITS'(1);

    localparam tol_t ZERO_TOL_RESET = TOL_BITS'(1);
    localparam tol_t GEOM_TOL_RESET = TOL_BITS'(66);

    localparam kind_t KIND_ELLIPSE   = KIND_BITS'(0);
    localparam kind_t KIND_HYPERBOLA = KIND_BITS'(1);
    localparam kind_t KIND_PARABOLA  = KIND_BITS'(2);

    function automatic dword_t mul2(word_t a, word_t b);
        return a * b;
    endfunction

    // Upper partial product: signed high word of p times k.
    function automatic dword_t mul_hi(dword_t p, word_t k);
        word_t hi;
        hi = $signed(p[2*WORD_BITS-1:WORD_BITS]);
        return hi * k;
    endfunction

    // Lower partial product: unsigned low word of p times k.
    function automatic part_t mul_lo(dword_t p, word_t k);
        logic signed [WORD_BITS:0] lo;
        lo = $signed({1'b0, p[WORD_BITS-1:0]});
        return lo * k;
    endfunction

    function automatic acc_t join_pp(dword_t hi, part_t lo);
        return (acc_t'(hi) <<< WORD_BITS) + acc_t'(lo);
    endfunction

    function automatic mag_t mag(acc_t v);
        return v[SUM_BITS-1] ? mag_t'(-v) : mag_t'(v);
    endfunction

endpackage

FILE: design/conic_arc_validator_core.sv
// Conic arc validator: five-stage pipeline classifying conics and checking arc end points.
//
// Takes one conic arc per clock while s_ready is high and returns one result per item.
// Stage 1 forms all 32x32 products, stage 2 splits each 64x32 product into two partial
// products and forms 4ac - b*b, stage 3 joins them, stage 4 sums the residuals, the
// determinant and classifies the conic, stage 5 compares magnitudes against the
// tolerances and holds the result. The whole pipe advances together: s_ready drops only
// while a result sits in the output register and m_ready is low. Configuration writes
// are taken in any cycle (cfg_ready is always high); an index other than 0 or 1 is
// ignored.
module conic_arc_validator_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [cav_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [cav_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [cav_pkg::WORD_BITS-1:0]  s_coef_a,
    input  logic signed [cav_pkg::WORD_BITS-1:0]  s_coef_b,
    input  logic signed [cav_pkg::WORD_BITS-1:0]  s_coef_c,
    input  logic signed [cav_pkg::WORD_BITS-1:0]  s_coef_d,
    input  logic signed [cav_pkg::WORD_BITS-1:0]  s_coef_e,
    input  logic signed [cav_pkg::WORD_BITS-1:0]  s_coef_f,
    input  logic signed [cav_pkg::WORD_BITS-1:0]  s_start_x,
    input  logic signed [cav_pkg::WORD_BITS-1:0]  s_start_y,
    input  logic signed [cav_pkg::WORD_BITS-1:0]  s_end_x,
    input  logic signed [cav_pkg::WORD_BITS-1:0]  s_end_y,
    input  logic [cav_pkg::FORM_BITS-1:0]         s_declared_form,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [cav_pkg::KIND_BITS-1:0]         m_conic_kind,
    output logic                                  m_form_mismatch,
    output logic                                  m_start_off_curve,
    output logic                                  m_end_off_curve,
    output logic                                  m_degenerate,
    output logic                                  m_all_valid
);

    localparam int NP = cav_pkg::POINTS;
    localparam int F  = cav_pkg::FRAC_BITS;

    cav_pkg::tol_t zero_tol_reg, zero_tol_next;
    cav_pkg::tol_t geom_tol_reg, geom_tol_next;

    logic advance;

    cav_pkg::word_t pt_x [NP];
    cav_pkg::word_t pt_y [NP];

    // stage 1
    logic            v1_reg;
    cav_pkg::dword_t s1_ac_reg, s1_bb_reg, s1_ee_reg, s1_dd_reg, s1_bd_reg;
    cav_pkg::dword_t s1_xx_reg [NP];
    cav_pkg::dword_t s1_xy_reg [NP];
    cav_pkg::dword_t s1_yy_reg [NP];
    cav_pkg::dword_t s1_dx_reg [NP];
    cav_pkg::dword_t s1_ey_reg [NP];
    cav_pkg::word_t  s1_a_reg, s1_b_reg, s1_c_reg, s1_e_reg, s1_f_reg;
    cav_pkg::form_t  s1_form_reg;

    // stage 2
    logic            v2_reg;
    cav_pkg::dword_t s2_fac_hi_reg, s2_aee_hi_reg, s2_fbb_hi_reg, s2_cdd_hi_reg, s2_ebd_hi_reg;
    cav_pkg::part_t  s2_fac_lo_reg, s2_aee_lo_reg, s2_fbb_lo_reg, s2_cdd_lo_reg, s2_ebd_lo_reg;
    cav_pkg::dword_t s2_axx_hi_reg [NP];
    cav_pkg::dword_t s2_bxy_hi_reg [NP];
    cav_pkg::dword_t s2_cyy_hi_reg [NP];
    cav_pkg::part_t  s2_axx_lo_reg [NP];
    cav_pkg::part_t  s2_bxy_lo_reg [NP];
    cav_pkg::part_t  s2_cyy_lo_reg [NP];
    cav_pkg::dword_t s2_dx_reg [NP];
    cav_pkg::dword_t s2_ey_reg [NP];
    cav_pkg::acc_t   s2_q2_reg;
    cav_pkg::word_t  s2_f_reg;
    cav_pkg::form_t  s2_form_reg;

    // stage 3
    logic            v3_reg;
    cav_pkg::acc_t   s3_fac_reg, s3_aee_reg, s3_fbb_reg, s3_cdd_reg, s3_ebd_reg;
    cav_pkg::acc_t   s3_axx_reg [NP];
    cav_pkg::acc_t   s3_bxy_reg [NP];
    cav_pkg::acc_t   s3_cyy_reg [NP];
    cav_pkg::dword_t s3_dx_reg [NP];
    cav_pkg::dword_t s3_ey_reg [NP];
    cav_pkg::acc_t   s3_q2_reg;
    cav_pkg::word_t  s3_f_reg;
    cav_pkg::form_t  s3_form_reg;

    // stage 4
    logic            v4_reg;
    cav_pkg::acc_t   s4_res_reg [NP];
    cav_pkg::acc_t   s4_q1_reg;
    cav_pkg::kind_t  s4_kind_reg;
    cav_pkg::form_t  s4_form_reg;
    cav_pkg::kind_t  kind_next;

    // stage 5 / output
    logic            v5_reg;
    cav_pkg::kind_t  out_kind_reg;
    logic            out_mismatch_reg, out_off_s_reg, out_off_e_reg, out_degen_reg;
    logic            out_ok_reg;
    logic [NP-1:0]   off_next;
    logic            mismatch_next, degen_next;
    cav_pkg::mag_t   res_lim, q1_lim, q2_lim;

    assign cfg_ready = 1'b1;
    assign advance   = !v5_reg || m_ready;
    assign s_ready   = advance;

    always_comb begin
        zero_tol_next = zero_tol_reg;
        geom_tol_next = geom_tol_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                cav_pkg::REG_ZERO_TOL: zero_tol_next = cfg_data[cav_pkg::TOL_BITS-1:0];
                cav_pkg::REG_GEOM_TOL: geom_tol_next = cfg_data[cav_pkg::TOL_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_tol_reg <= cav_pkg::ZERO_TOL_RESET;
            geom_tol_reg <= cav_pkg::GEOM_TOL_RESET;
        end else begin
            zero_tol_reg <= zero_tol_next;
            geom_tol_reg <= geom_tol_next;
        end
    end

    always_comb begin
        pt_x[0] = s_start_x;
        pt_y[0] = s_start_y;
        pt_x[1] = s_end_x;
        pt_y[1] = s_end_y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // stage 1: word products
    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_ac_reg   <= cav_pkg::mul2(s_coef_a, s_coef_c);
            s1_bb_reg   <= cav_pkg::mul2(s_coef_b, s_coef_b);
            s1_ee_reg   <= cav_pkg::mul2(s_coef_e, s_coef_e);
            s1_dd_reg   <= cav_pkg::mul2(s_coef_d, s_coef_d);
            s1_bd_reg   <= cav_pkg::mul2(s_coef_b, s_coef_d);
            for (int i = 0; i < NP; i++) begin
                s1_xx_reg[i] <= cav_pkg::mul2(pt_x[i], pt_x[i]);
                s1_xy_reg[i] <= cav_pkg::mul2(pt_x[i], pt_y[i]);
                s1_yy_reg[i] <= cav_pkg::mul2(pt_y[i], pt_y[i]);
                s1_dx_reg[i] <= cav_pkg::mul2(s_coef_d, pt_x[i]);
                s1_ey_reg[i] <= cav_pkg::mul2(s_coef_e, pt_y[i]);
            end
            s1_a_reg    <= s_coef_a;
            s1_b_reg    <= s_coef_b;
            s1_c_reg    <= s_coef_c;
            s1_e_reg    <= s_coef_e;
            s1_f_reg    <= s_coef_f;
            s1_form_reg <= s_declared_form;
        end
    end

    // stage 2: partial products of the triple products
    always_ff @(posedge aclk) begin
        if (advance) begin
            s2_fac_hi_reg <= cav_pkg::mul_hi(s1_ac_reg, s1_f_reg);
            s2_fac_lo_reg <= cav_pkg::mul_lo(s1_ac_reg, s1_f_reg);
            s2_aee_hi_reg <= cav_pkg::mul_hi(s1_ee_reg, s1_a_reg);
            s2_aee_lo_reg <= cav_pkg::mul_lo(s1_ee_reg, s1_a_reg);
            s2_fbb_hi_reg <= cav_pkg::mul_hi(s1_bb_reg, s1_f_reg);
            s2_fbb_lo_reg <= cav_pkg::mul_lo(s1_bb_reg, s1_f_reg);
            s2_cdd_hi_reg <= cav_pkg::mul_hi(s1_dd_reg, s1_c_reg);
            s2_cdd_lo_reg <= cav_pkg::mul_lo(s1_dd_reg, s1_c_reg);
            s2_ebd_hi_reg <= cav_pkg::mul_hi(s1_bd_reg, s1_e_reg);
            s2_ebd_lo_reg <= cav_pkg::mul_lo(s1_bd_reg, s1_e_reg);
            for (int i = 0; i < NP; i++) begin
                s2_axx_hi_reg[i] <= cav_pkg::mul_hi(s1_xx_reg[i], s1_a_reg);
                s2_axx_lo_reg[i] <= cav_pkg::mul_lo(s1_xx_reg[i], s1_a_reg);
                s2_bxy_hi_reg[i] <= cav_pkg::mul_hi(s1_xy_reg[i], s1_b_reg);
                s2_bxy_lo_reg[i] <= cav_pkg::mul_lo(s1_xy_reg[i], s1_b_reg);
                s2_cyy_hi_reg[i] <= cav_pkg::mul_hi(s1_yy_reg[i], s1_c_reg);
                s2_cyy_lo_reg[i] <= cav_pkg::mul_lo(s1_yy_reg[i], s1_c_reg);
                s2_dx_reg[i]     <= s1_dx_reg[i];
                s2_ey_reg[i]     <= s1_ey_reg[i];
            end
            s2_q2_reg   <= (cav_pkg::acc_t'(s1_ac_reg) <<< 2) - cav_pkg::acc_t'(s1_bb_reg);
            s2_f_reg    <= s1_f_reg;
            s2_form_reg <= s1_form_reg;
        end
    end

    // stage 3: join partial products
    always_ff @(posedge aclk) begin
        if (advance) begin
            s3_fac_reg <= cav_pkg::join_pp(s2_fac_hi_reg, s2_fac_lo_reg);
            s3_aee_reg <= cav_pkg::join_pp(s2_aee_hi_reg, s2_aee_lo_reg);
            s3_fbb_reg <= cav_pkg::join_pp(s2_fbb_hi_reg, s2_fbb_lo_reg);
            s3_cdd_reg <= cav_pkg::join_pp(s2_cdd_hi_reg, s2_cdd_lo_reg);
            s3_ebd_reg <= cav_pkg::join_pp(s2_ebd_hi_reg, s2_ebd_lo_reg);
            for (int i = 0; i < NP; i++) begin
                s3_axx_reg[i] <= cav_pkg::join_pp(s2_axx_hi_reg[i], s2_axx_lo_reg[i]);
                s3_bxy_reg[i] <= cav_pkg::join_pp(s2_bxy_hi_reg[i], s2_bxy_lo_reg[i]);
                s3_cyy_reg[i] <= cav_pkg::join_pp(s2_cyy_hi_reg[i], s2_cyy_lo_reg[i]);
                s3_dx_reg[i]  <= s2_dx_reg[i];
                s3_ey_reg[i]  <= s2_ey_reg[i];
            end
            s3_q2_reg   <= s2_q2_reg;
            s3_f_reg    <= s2_f_reg;
            s3_form_reg <= s2_form_reg;
        end
    end

    // stage 4: residuals, determinant, classification
    assign q2_lim = cav_pkg::mag_t'(zero_tol_reg) << (F + 2);

    always_comb begin
        if (cav_pkg::mag(s3_q2_reg) < q2_lim) begin
            kind_next = cav_pkg::KIND_PARABOLA;
        end else if (s3_q2_reg[cav_pkg::SUM_BITS-1]) begin
            kind_next = cav_pkg::KIND_HYPERBOLA;
        end else begin
            kind_next = cav_pkg::KIND_ELLIPSE;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 0; i < NP; i++) begin
                s4_res_reg[i] <= s3_axx_reg[i] + s3_bxy_reg[i] + s3_cyy_reg[i]
                               + (cav_pkg::acc_t'(s3_dx_reg[i]) <<< F)
                               + (cav_pkg::acc_t'(s3_ey_reg[i]) <<< F)
                               + (cav_pkg::acc_t'(s3_f_reg) <<< (2 * F));
            end
            s4_q1_reg   <= (s3_fac_reg <<< 2) - s3_aee_reg - s3_fbb_reg - s3_cdd_reg
                         + s3_ebd_reg;
            s4_kind_reg <= kind_next;
            s4_form_reg <= s3_form_reg;
        end
    end

    // stage 5: tolerance compares
    assign res_lim = cav_pkg::mag_t'(geom_tol_reg) << (2 * F);
    assign q1_lim  = cav_pkg::mag_t'(geom_tol_reg) << (2 * F + 2);

    always_comb begin
        for (int i = 0; i < NP; i++) begin
            off_next[i] = !(cav_pkg::mag(s4_res_reg[i]) < res_lim);
        end
        degen_next    = cav_pkg::mag(s4_q1_reg) < q1_lim;
        mismatch_next = s4_form_reg != (cav_pkg::form_t'(s4_kind_reg) + cav_pkg::form_t'(1));
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_kind_reg     <= s4_kind_reg;
            out_mismatch_reg <= mismatch_next;
            out_off_s_reg    <= off_next[0];
            out_off_e_reg    <= off_next[1];
            out_degen_reg    <= degen_next;
            out_ok_reg       <= !(mismatch_next || (|off_next) || degen_next);
        end
    end

    assign m_valid           = v5_reg;
    assign m_conic_kind      = out_kind_reg;
    assign m_form_mismatch   = out_mismatch_reg;
    assign m_start_off_curve = out_off_s_reg;
    assign m_end_off_curve   = out_off_e_reg;
    assign m_degenerate      = out_degen_reg;
    assign m_all_valid       = out_ok_reg;

endmodule

FILE: test/conic_arc_validator_core_tb.sv
// Testbench for conic_arc_validator_core: directed and random conic arcs checked against a predictor.
module conic_arc_validator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    localparam cav_pkg::form_t FORM_NONE      = cav_pkg::FORM_BITS'(0);
    localparam cav_pkg::form_t FORM_ELLIPSE   = cav_pkg::FORM_BITS'(1);
    localparam cav_pkg::form_t FORM_HYPERBOLA = cav_pkg::FORM_BITS'(2);
    localparam cav_pkg::form_t FORM_PARABOLA  = cav_pkg::FORM_BITS'(3);

    localparam logic [cav_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_LO = cav_pkg::CFG_INDEX_BITS'(2);
    localparam logic [cav_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_HI = '1;

    localparam cav_pkg::word_t ONE  = 32'sh0001_0000;
    localparam cav_pkg::word_t MAXW = 32'sh7FFF_FFFF;
    localparam cav_pkg::word_t MINW = 32'sh8000_0000;
    localparam cav_pkg::word_t NEG1 = 32'shFFFF_FFFF;

    typedef logic signed [127:0] big_t;
    localparam big_t SCALE = big_t'(1 << cav_pkg::FRAC_BITS);

    typedef struct packed {
        cav_pkg::word_t coef_a;
        cav_pkg::word_t coef_b;
        cav_pkg::word_t coef_c;
        cav_pkg::word_t coef_d;
        cav_pkg::word_t coef_e;
        cav_pkg::word_t coef_f;
        cav_pkg::word_t start_x;
        cav_pkg::word_t start_y;
        cav_pkg::word_t end_x;
        cav_pkg::word_t end_y;
        cav_pkg::form_t declared_form;
    } arc_t;

    typedef struct packed {
        cav_pkg::kind_t kind;
        logic           mismatch;
        logic           start_off;
        logic           end_off;
        logic           degenerate;
        logic           all_valid;
    } verdict_t;

    typedef struct {
        arc_t     arc;
        bit       typed;
        verdict_t verdict;
    } row_t;

    logic                               aclk = 1'b0;
    logic                               aresetn;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [cav_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [cav_pkg::CFG_DATA_BITS-1:0]  cfg_data;
    logic                               s_valid;
    logic                               s_ready;
    cav_pkg::word_t                     s_coef_a;
    cav_pkg::word_t                     s_coef_b;
    cav_pkg::word_t                     s_coef_c;
    cav_pkg::word_t                     s_coef_d;
    cav_pkg::word_t                     s_coef_e;
    cav_pkg::word_t                     s_coef_f;
    cav_pkg::word_t                     s_start_x;
    cav_pkg::word_t                     s_start_y;
    cav_pkg::word_t                     s_end_x;
    cav_pkg::word_t                     s_end_y;
    cav_pkg::form_t                     s_declared_form;
    logic                               m_valid;
    logic                               m_ready;
    cav_pkg::kind_t                     m_conic_kind;
    logic                               m_form_mismatch;
    logic                               m_start_off_curve;
    logic                               m_end_off_curve;
    logic                               m_degenerate;
    logic                               m_all_valid;

    cav_pkg::tol_t zero_tol;
    cav_pkg::tol_t geom_tol;
    verdict_t      verdict_q[$];
    verdict_t      want;
    int            fail_count = 0;
    int            cycle_count;
    bit            calm = 1'b0;

    conic_arc_validator_core DUT (.*);

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic big_t mag_of(big_t v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic cav_pkg::form_t form_of(cav_pkg::kind_t kind);
        case (kind)
            cav_pkg::KIND_ELLIPSE:   return FORM_ELLIPSE;
            cav_pkg::KIND_HYPERBOLA: return FORM_HYPERBOLA;
            default:                 return FORM_PARABOLA;
        endcase
    endfunction

    function automatic logic off_curve(arc_t arc, cav_pkg::word_t xw, cav_pkg::word_t yw);
        big_t a, b, c, d, e, f, x, y, r, lim;
        a = big_t'(arc.coef_a);
        b = big_t'(arc.coef_b);
        c = big_t'(arc.coef_c);
        d = big_t'(arc.coef_d);
        e = big_t'(arc.coef_e);
        f = big_t'(arc.coef_f);
        x = big_t'(xw);
        y = big_t'(yw);
        lim = big_t'(geom_tol);
        r = a * x * x + b * x * y + c * y * y + SCALE * (d * x + e * y) + SCALE * SCALE * f;
        return !(mag_of(r) < lim * SCALE * SCALE);
    endfunction

    function automatic verdict_t judge_arc(arc_t arc);
        verdict_t v;
        big_t a, b, c, d, e, f, q1, q2, ztol, gtol;
        a = big_t'(arc.coef_a);
        b = big_t'(arc.coef_b);
        c = big_t'(arc.coef_c);
        d = big_t'(arc.coef_d);
        e = big_t'(arc.coef_e);
        f = big_t'(arc.coef_f);
        ztol = big_t'(zero_tol);
        gtol = big_t'(geom_tol);
        q2 = 4 * a * c - b * b;
        if (mag_of(q2) < 4 * ztol * SCALE) begin
            v.kind = cav_pkg::KIND_PARABOLA;
        end else if (q2 < 0) begin
            v.kind = cav_pkg::KIND_HYPERBOLA;
        end else begin
            v.kind = cav_pkg::KIND_ELLIPSE;
        end
        v.mismatch = (arc.declared_form != form_of(v.kind));
        v.start_off = off_curve(arc, arc.start_x, arc.start_y);
        v.end_off = off_curve(arc, arc.end_x, arc.end_y);
        q1 = 4 * a * c * f - a * e * e - b * b * f - c * d * d + b * d * e;
        v.degenerate = mag_of(q1) < 4 * gtol * SCALE * SCALE;
        v.all_valid = !(v.mismatch | v.start_off | v.end_off | v.degenerate);
        return v;
    endfunction

    function automatic int span(int n);
        return int'($urandom_range(0, 2 * n)) - n;
    endfunction

    function automatic cav_pkg::word_t noise_word();
        case ($urandom_range(0, 7))
            0:       return MINW;
            1:       return MAXW;
            2:       return '0;
            3:       return span(256);
            default: return $urandom;
        endcase
    endfunction

    function automatic arc_t random_arc();
        arc_t     arc;
        verdict_t v;
        int       a, b, c, d, e, f, u, w, sx, sy, ex, ey;
        int       p1, q1, r1, p2, q2, r2, t;
        case ($urandom_range(0, 9))
            0, 1: begin
                arc.coef_a = noise_word();
                arc.coef_b = noise_word();
                arc.coef_c = noise_word();
                arc.coef_d = noise_word();
                arc.coef_e = noise_word();
                arc.coef_f = noise_word();
                arc.start_x = noise_word();
                arc.start_y = noise_word();
                arc.end_x = noise_word();
                arc.end_y = noise_word();
                arc.declared_form = cav_pkg::form_t'($urandom_range(0, 3));
                return arc;
            end
            7, 8: begin
                // pair of lines through both end points
                p1 = span(64);
                q1 = span(64);
                p2 = span(64);
                q2 = span(64);
                r2 = span(64);
                sx = span(16);
                sy = span(16);
                t = span(3);
                r1 = -(p1 * sx + q1 * sy);
                ex = sx + q1 * t;
                ey = sy - p1 * t;
                a = p1 * p2;
                b = p1 * q2 + p2 * q1;
                c = q1 * q2;
                d = p1 * r2 + p2 * r1;
                e = q1 * r2 + q2 * r1;
                f = r1 * r2;
            end
            9: begin
                a = span(8);
                b = span(8);
                c = span(8);
                d = span(4096);
                e = span(4096);
                f = span(4096);
                sx = span(4);
                sy = span(4);
                ex = span(4);
                ey = span(4);
            end
            default: begin
                a = span(4096);
                b = span(4096);
                c = span(4096);
                d = span(4096);
                e = span(4096);
                if ($urandom_range(0, 3) == 0) begin
                    u = span(40);
                    w = span(40);
                    a = u * u;
                    c = w * w;
                    b = 2 * u * w;
                    if ($urandom_range(0, 1) == 1) begin
                        a = -a;
                        c = -c;
                    end
                end
                sx = span(16);
                sy = span(16);
                case ($urandom_range(0, 2))
                    0: begin
                        d = 0;
                        e = 0;
                        ex = -sx;
                        ey = -sy;
                    end
                    1: begin
                        ex = sx;
                        ey = sy;
                    end
                    default: begin
                        ex = span(16);
                        ey = span(16);
                    end
                endcase
                f = -(a * sx * sx + b * sx * sy + c * sy * sy + d * sx + e * sy);
                if ($urandom_range(0, 1) == 1) f += span(100);
            end
        endcase
        arc.coef_a = a;
        arc.coef_b = b;
        arc.coef_c = c;
        arc.coef_d = d;
        arc.coef_e = e;
        arc.coef_f = f;
        arc.start_x = sx * (1 << cav_pkg::FRAC_BITS);
        arc.start_y = sy * (1 << cav_pkg::FRAC_BITS);
        arc.end_x = ex * (1 << cav_pkg::FRAC_BITS);
        arc.end_y = ey * (1 << cav_pkg::FRAC_BITS);
        if ($urandom_range(0, 3) == 0) arc.start_x += span(4);
        if ($urandom_range(0, 3) == 0) arc.end_y += span(4);
        arc.declared_form = cav_pkg::form_t'($urandom_range(0, 3));
        if ($urandom_range(0, 3) != 0) begin
            v = judge_arc(arc);
            arc.declared_form = form_of(v.kind);
        end
        return arc;
    endfunction

    function automatic row_t arc_row(cav_pkg::word_t a, b, c, d, e, f, sx, sy, ex, ey,
                                     cav_pkg::form_t form,
                                     bit typed = 1'b0, verdict_t known = '0);
        row_t r;
        r.arc = '{a, b, c, d, e, f, sx, sy, ex, ey, form};
        r.typed = typed;
        r.verdict = known;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] expected,
                                        logic [31:0] actual);
        if (actual !== expected) begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            fail_count++;
        end
    endfunction

    task automatic write_reg(logic [cav_pkg::CFG_INDEX_BITS-1:0] index,
                             logic [cav_pkg::CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            cav_pkg::REG_ZERO_TOL: zero_tol = data[cav_pkg::TOL_BITS-1:0];
            cav_pkg::REG_GEOM_TOL: geom_tol = data[cav_pkg::TOL_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic send_arc(arc_t arc, bit typed, verdict_t known, bit last, bit may_idle);
        s_valid <= 1'b1;
        s_coef_a <= arc.coef_a;
        s_coef_b <= arc.coef_b;
        s_coef_c <= arc.coef_c;
        s_coef_d <= arc.coef_d;
        s_coef_e <= arc.coef_e;
        s_coef_f <= arc.coef_f;
        s_start_x <= arc.start_x;
        s_start_y <= arc.start_y;
        s_end_x <= arc.end_x;
        s_end_y <= arc.end_y;
        s_declared_form <= arc.declared_form;
        do @(posedge aclk); while (!s_ready);
        verdict_q.push_back(typed ? known : judge_arc(arc));
        if (last) begin
            s_valid <= 1'b0;
        end else if (may_idle && !calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    initial begin : result_stall
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 30) == 0) begin
                repeat ($urandom_range(20, 60)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $error("result transfer with no expectation pending");
                fail_count++;
            end else begin
                want = verdict_q.pop_front();
                check_field("conic_kind", 32'(want.kind), 32'(m_conic_kind));
                check_field("form_mismatch", 32'(want.mismatch), 32'(m_form_mismatch));
                check_field("start_off_curve", 32'(want.start_off), 32'(m_start_off_curve));
                check_field("end_off_curve", 32'(want.end_off), 32'(m_end_off_curve));
                check_field("degenerate", 32'(want.degenerate), 32'(m_degenerate));
                check_field("all_valid", 32'(want.all_valid), 32'(m_all_valid));
            end
        end
    end

    initial begin : watchdog
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge aclk);
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        row_t arc_rows[$];
        int   count;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_coef_a = '0;
        s_coef_b = '0;
        s_coef_c = '0;
        s_coef_d = '0;
        s_coef_e = '0;
        s_coef_f = '0;
        s_start_x = '0;
        s_start_y = '0;
        s_end_x = '0;
        s_end_y = '0;
        s_declared_form = FORM_NONE;
        zero_tol = cav_pkg::ZERO_TOL_RESET;
        geom_tol = cav_pkg::GEOM_TOL_RESET;

        arc_rows.push_back(arc_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, FORM_PARABOLA,
                                   1'b1, {cav_pkg::KIND_PARABOLA, 5'b00010}));
        arc_rows.push_back(arc_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, FORM_NONE,
                                   1'b1, {cav_pkg::KIND_PARABOLA, 5'b10010}));
        arc_rows.push_back(arc_row(ONE, 0, ONE, 0, 0, -ONE, ONE, 0, 0, ONE, FORM_ELLIPSE,
                                   1'b1, {cav_pkg::KIND_ELLIPSE, 5'b00001}));
        arc_rows.push_back(arc_row(ONE, 0, -ONE, 0, 0, -ONE, ONE, 0, -ONE, 0, FORM_HYPERBOLA,
                                   1'b1, {cav_pkg::KIND_HYPERBOLA, 5'b00001}));
        arc_rows.push_back(arc_row(0, 0, ONE, -ONE, 0, 0, 0, 0, ONE, ONE, FORM_PARABOLA,
                                   1'b1, {cav_pkg::KIND_PARABOLA, 5'b00001}));
        arc_rows.push_back(arc_row(ONE, 0, ONE, 0, 0, -ONE, 0, 0, 2 * ONE, 0, FORM_ELLIPSE,
                                   1'b1, {cav_pkg::KIND_ELLIPSE, 5'b01100}));
        arc_rows.push_back(arc_row(ONE, 0, ONE, 0, 0, -ONE, ONE, 0, 0, ONE, FORM_HYPERBOLA,
                                   1'b1, {cav_pkg::KIND_ELLIPSE, 5'b10000}));
        arc_rows.push_back(arc_row(ONE, 0, ONE, 0, 0, -ONE, ONE, 0, 0, ONE, FORM_NONE,
                                   1'b1, {cav_pkg::KIND_ELLIPSE, 5'b10000}));
        arc_rows.push_back(arc_row(ONE, 0, -ONE, 0, 0, 0, ONE, ONE, ONE, -ONE, FORM_HYPERBOLA,
                                   1'b1, {cav_pkg::KIND_HYPERBOLA, 5'b00010}));
        arc_rows.push_back(arc_row(ONE, 0, ONE, 0, 0, 0, 0, 0, 0, 0, FORM_ELLIPSE,
                                   1'b1, {cav_pkg::KIND_ELLIPSE, 5'b00010}));
        arc_rows.push_back(arc_row(1, 0, ONE, 0, 0, 0, 0, 0, 0, 0, FORM_ELLIPSE,
                                   1'b1, {cav_pkg::KIND_ELLIPSE, 5'b00010}));
        arc_rows.push_back(arc_row(1, 0, ONE - 1, 0, 0, 0, 0, 0, 0, 0, FORM_ELLIPSE,
                                   1'b1, {cav_pkg::KIND_PARABOLA, 5'b10010}));
        arc_rows.push_back(arc_row(-1, 0, ONE, 0, 0, 0, 0, 0, 0, 0, FORM_HYPERBOLA,
                                   1'b1, {cav_pkg::KIND_HYPERBOLA, 5'b00010}));
        arc_rows.push_back(arc_row(0, 0, 0, 0, 0, 66, 0, 0, 0, 0, FORM_PARABOLA,
                                   1'b1, {cav_pkg::KIND_PARABOLA, 5'b01110}));
        arc_rows.push_back(arc_row(0, 0, 0, 0, 0, 65, 0, 0, 0, 0, FORM_PARABOLA,
                                   1'b1, {cav_pkg::KIND_PARABOLA, 5'b00010}));
        arc_rows.push_back(arc_row(0, 0, 0, 0, 0, -66, 0, 0, 0, 0, FORM_PARABOLA,
                                   1'b1, {cav_pkg::KIND_PARABOLA, 5'b01110}));
        arc_rows.push_back(arc_row(MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW,
                                   FORM_PARABOLA));
        arc_rows.push_back(arc_row(MINW, MINW, MINW, MINW, MINW, MINW, MINW, MINW, MINW, MINW,
                                   FORM_NONE));
        arc_rows.push_back(arc_row(MINW, MAXW, MAXW, MINW, MAXW, MINW, MAXW, MINW, MINW, MAXW,
                                   FORM_ELLIPSE));
        arc_rows.push_back(arc_row(NEG1, NEG1, NEG1, NEG1, NEG1, NEG1, NEG1, NEG1, NEG1, NEG1,
                                   FORM_HYPERBOLA));

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (arc_rows[i]) begin
            send_arc(arc_rows[i].arc, arc_rows[i].typed, arc_rows[i].verdict,
                     i == arc_rows.size() - 1, 1'b1);
        end

        for (int ph = 0; ph < 6; ph++) begin
            while (verdict_q.size() != 0) @(posedge aclk);
            case (ph)
                1: begin
                    write_reg(cav_pkg::REG_ZERO_TOL, '0);
                    write_reg(cav_pkg::REG_GEOM_TOL, '0);
                    write_reg(REG_SPARE_LO, $urandom);
                end
                2: begin
                    write_reg(cav_pkg::REG_ZERO_TOL, 32'hFFFF_FFFF);
                    write_reg(cav_pkg::REG_GEOM_TOL, 32'h7FFF_FFFF);
                end
                3: begin
                    write_reg(cav_pkg::REG_ZERO_TOL,
                              $urandom_range(0, 1 << 20) | ($urandom & 32'h8000_0000));
                    write_reg(cav_pkg::REG_GEOM_TOL,
                              $urandom_range(0, 4096) | ($urandom & 32'h8000_0000));
                end
                4: begin
                    write_reg(REG_SPARE_HI, $urandom);
                    write_reg(cav_pkg::REG_ZERO_TOL, $urandom);
                    write_reg(cav_pkg::REG_GEOM_TOL, $urandom_range(0, 200));
                end
                5: begin
                    write_reg(cav_pkg::REG_ZERO_TOL, 32'h8000_0001);
                    write_reg(cav_pkg::REG_GEOM_TOL, 66);
                end
                default: ;
            endcase
            cfg_valid <= 1'b0;
            calm = (ph == 5);
            count = calm ? 400 : 300;
            for (int n = 0; n < count; n++) begin
                send_arc(random_arc(), 1'b0, '0, n == count - 1, (n % 120) >= 40);
            end
        end

        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && verdict_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/cav_pkg.sv
design/conic_arc_validator_core.sv
test/conic_arc_validator_core_tb.sv
